// ===== hw/rtl/ctcgd_pkg.sv =====
package ctcgd_pkg;

    // defaults for the top level parameters
    localparam int MAX_CLASSES_DEF = 8192;
    localparam int MAX_STEPS_DEF   = 256;

    // fixed field widths
    localparam int SCORE_W     = 16;
    localparam int CLASS_OUT_W = 13;
    localparam int MEAN_W      = 16;
    localparam int COUNT_OUT_W = 9;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // entries between front and back
    localparam int QUEUE_DEPTH = 2;

    // result kinds carried on m_tuser
    localparam logic KIND_CLASS   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // result payload, lowest field last
    typedef struct packed {
        logic                   spare;
        logic                   empty_res;
        logic [COUNT_OUT_W-1:0] char_count;
        logic [MEAN_W-1:0]      mean_score;
        logic [CLASS_OUT_W-1:0] class_index;
    } result_t;

endpackage

// ===== hw/rtl/ctcgd_fifo.sv =====
module ctcgd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ctcgd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             valid,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data
);
    import ctcgd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/ctcgd_front.sv =====
module ctcgd_front #(
    parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF,
    parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF,
    localparam int IDX_W = $clog2(MAX_CLASSES),
    localparam int CNT_W = $clog2(MAX_STEPS + 1),
    localparam int SUM_W = ctcgd_pkg::SCORE_W + CNT_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctcgd_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           s_tuser,
    output logic                           q_push,
    input  logic                           q_full,
    output logic                           q_emit,
    output logic [IDX_W-1:0]               q_class,
    output logic                           q_seq_end,
    output logic [SUM_W-1:0]               q_sum,
    output logic [CNT_W-1:0]               q_count
);
    import ctcgd_pkg::*;

    localparam int POS_W = $clog2(MAX_CLASSES + 1);

    logic [POS_W-1:0]   class_pos_reg;
    logic [POS_W-1:0]   class_pos_next;
    logic [SCORE_W-1:0] best_value_reg;
    logic [SCORE_W-1:0] best_value_next;
    logic [IDX_W-1:0]   best_index_reg;
    logic [IDX_W-1:0]   best_index_next;
    logic [IDX_W-1:0]   prev_index_reg;
    logic [IDX_W-1:0]   prev_index_next;
    logic               first_step_reg;
    logic               first_step_next;
    logic [SUM_W-1:0]   score_sum_reg;
    logic [SUM_W-1:0]   score_sum_next;
    logic [CNT_W-1:0]   emit_count_reg;
    logic [CNT_W-1:0]   emit_count_next;

    logic               accept;
    logic [SCORE_W-1:0] score;
    logic               end_step;
    logic               end_seq;
    logic               in_range;
    logic               take;
    logic [SCORE_W-1:0] cur_value;
    logic [IDX_W-1:0]   cur_index;
    logic               emit;
    logic [SUM_W-1:0]   sum_upd;
    logic [CNT_W-1:0]   cnt_upd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign score    = s_tdata[SCORE_W-1:0];
    assign end_step = s_tlast;
    assign end_seq  = s_tlast && s_tuser;

    always_comb
    begin
        in_range  = (class_pos_reg < POS_W'(MAX_CLASSES));
        take      = in_range && ((class_pos_reg == '0) || (score > best_value_reg));
        cur_value = take ? score : best_value_reg;
        cur_index = take ? class_pos_reg[IDX_W-1:0] : best_index_reg;
        // first maximum of the step wins, repeats and blank are collapsed
        emit      = end_step && (cur_index != '0)
                    && (first_step_reg || (cur_index != prev_index_reg))
                    && (emit_count_reg < CNT_W'(MAX_STEPS));
        sum_upd   = score_sum_reg + (emit ? SUM_W'(cur_value) : '0);
        cnt_upd   = emit_count_reg + CNT_W'(emit);

        class_pos_next  = class_pos_reg;
        best_value_next = best_value_reg;
        best_index_next = best_index_reg;
        prev_index_next = prev_index_reg;
        first_step_next = first_step_reg;
        score_sum_next  = score_sum_reg;
        emit_count_next = emit_count_reg;

        if (accept)
        begin
            if (!end_step)
            begin
                if (in_range)
                begin
                    best_value_next = cur_value;
                    best_index_next = cur_index;
                    class_pos_next  = class_pos_reg + POS_W'(1);
                end
            end
            else
            begin
                class_pos_next  = '0;
                best_value_next = '0;
                best_index_next = '0;
                if (end_seq)
                begin
                    prev_index_next = '0;
                    first_step_next = 1'b1;
                    score_sum_next  = '0;
                    emit_count_next = '0;
                end
                else
                begin
                    prev_index_next = cur_index;
                    first_step_next = 1'b0;
                    score_sum_next  = sum_upd;
                    emit_count_next = cnt_upd;
                end
            end
        end
    end

    // one queue entry per step end that produces any result
    assign q_push    = accept && end_step && (emit || end_seq);
    assign q_emit    = emit;
    assign q_class   = cur_index;
    assign q_seq_end = end_seq;
    assign q_sum     = sum_upd;
    assign q_count   = cnt_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_pos_reg  <= '0;
            best_value_reg <= '0;
            best_index_reg <= '0;
            prev_index_reg <= '0;
            first_step_reg <= 1'b1;
            score_sum_reg  <= '0;
            emit_count_reg <= '0;
        end
        else
        begin
            class_pos_reg  <= class_pos_next;
            best_value_reg <= best_value_next;
            best_index_reg <= best_index_next;
            prev_index_reg <= prev_index_next;
            first_step_reg <= first_step_next;
            score_sum_reg  <= score_sum_next;
            emit_count_reg <= emit_count_next;
        end
    end

endmodule

// ===== hw/rtl/ctcgd_back.sv =====
module ctcgd_back #(
    parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF,
    parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF,
    localparam int IDX_W = $clog2(MAX_CLASSES),
    localparam int CNT_W = $clog2(MAX_STEPS + 1),
    localparam int SUM_W = ctcgd_pkg::SCORE_W + CNT_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  logic                            q_emit,
    input  logic [IDX_W-1:0]                q_class,
    input  logic                            q_seq_end,
    input  logic [SUM_W-1:0]                q_sum,
    input  logic [CNT_W-1:0]                q_count,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ctcgd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import ctcgd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIV
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   class_reg;
    logic [IDX_W-1:0]   class_next;
    logic               seq_end_reg;
    logic               seq_end_next;
    logic [CNT_W-1:0]   divisor_reg;
    logic [CNT_W-1:0]   divisor_next;
    logic [SUM_W-1:0]   quo_reg;
    logic [SUM_W-1:0]   quo_next;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   rem_next;
    logic [STEP_W-1:0]  div_left_reg;
    logic [STEP_W-1:0]  div_left_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    result_t            m_data_reg;
    result_t            m_data_next;
    logic               m_last_reg;
    logic               m_last_next;
    logic               m_kind_reg;
    logic               m_kind_next;

    logic               out_free;
    logic [CNT_W:0]     shifted;
    logic [CNT_W:0]     diff;
    logic               ge;
    logic               empty;

    assign out_free = !m_valid_reg || m_tready;
    assign empty    = (divisor_reg == '0);

    always_comb
    begin
        // restoring division, one quotient bit per cycle
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        ge      = (shifted >= {1'b0, divisor_reg});

        state_next    = state_reg;
        class_next    = class_reg;
        seq_end_next  = seq_end_reg;
        divisor_next  = divisor_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        div_left_next = div_left_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_kind_next   = m_kind_reg;
        q_pop         = 1'b0;

        if (div_left_reg != '0)
        begin
            rem_next      = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next      = {quo_reg[SUM_W-2:0], ge};
            div_left_next = div_left_reg - STEP_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    class_next    = q_class;
                    seq_end_next  = q_seq_end;
                    divisor_next  = q_count;
                    quo_next      = q_sum;
                    rem_next      = '0;
                    div_left_next = STEP_W'(SUM_W);
                    state_next    = q_emit ? ST_CLASS : ST_DIV;
                end
            end
            ST_CLASS:
            begin
                if (out_free)
                begin
                    m_valid_next            = 1'b1;
                    m_kind_next             = KIND_CLASS;
                    m_last_next             = !seq_end_reg;
                    m_data_next             = '0;
                    m_data_next.class_index = CLASS_OUT_W'(class_reg);
                    state_next              = seq_end_reg ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if ((div_left_reg == '0) && out_free)
                begin
                    m_valid_next           = 1'b1;
                    m_kind_next            = KIND_SUMMARY;
                    m_last_next            = 1'b1;
                    m_data_next            = '0;
                    m_data_next.empty_res  = empty;
                    m_data_next.char_count = COUNT_OUT_W'(divisor_reg);
                    // a zero count would give all ones from the divider
                    m_data_next.mean_score = empty ? '0 : MEAN_W'(quo_reg);
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            div_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            div_left_reg <= div_left_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg   <= class_next;
        seq_end_reg <= seq_end_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_kind_reg  <= m_kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_kind_reg;

endmodule

// ===== hw/rtl/ctc_greedy_decoder_core.sv =====
// greedy ctc decoder: takes one class score per cycle, steps of scores back to back, and keeps
// the first maximum of each step; a step whose winner is not blank and differs from the previous
// winner yields a class transaction, and the end of a sequence yields a summary transaction with
// the character count and the truncated mean of the emitted maxima (mean 0 and empty_res set when
// nothing was emitted). the front argmax stage takes a score every cycle; each step end that has
// results goes into a two-entry queue, and the back stage computes the mean with a restoring
// divider that runs while the next sequence streams in. the input stalls only when two further
// step ends with results are queued before the back stage is done, or when results are not taken
// at the output.
module ctc_greedy_decoder_core #(
    parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF,
    parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ctcgd_pkg::IN_DATA_W-1:0]  s_tdata,  // score[15:0]
    input  logic                             s_tlast,  // last_in_step
    input  logic                             s_tuser,  // last_in_sequence
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // class_index[12:0], mean_score[28:13], char_count[37:29], empty_res[38], zero[39]
    output logic [ctcgd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                             m_tlast,  // last
    output logic                             m_tuser   // kind
);
    import ctcgd_pkg::*;

    localparam int IDX_W   = $clog2(MAX_CLASSES);
    localparam int CNT_W   = $clog2(MAX_STEPS + 1);
    localparam int SUM_W   = SCORE_W + CNT_W;
    localparam int ENTRY_W = 2 + IDX_W + SUM_W + CNT_W;

    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               f_emit;
    logic [IDX_W-1:0]   f_class;
    logic               f_seq_end;
    logic [SUM_W-1:0]   f_sum;
    logic [CNT_W-1:0]   f_count;
    logic               b_emit;
    logic [IDX_W-1:0]   b_class;
    logic               b_seq_end;
    logic [SUM_W-1:0]   b_sum;
    logic [CNT_W-1:0]   b_count;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    ctcgd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_emit    (f_emit),
        .q_class   (f_class),
        .q_seq_end (f_seq_end),
        .q_sum     (f_sum),
        .q_count   (f_count)
    );

    assign wr_entry = {f_emit, f_class, f_seq_end, f_sum, f_count};

    ctcgd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (wr_entry),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .rd_data (rd_entry)
    );

    assign {b_emit, b_class, b_seq_end, b_sum, b_count} = rd_entry;

    ctcgd_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_emit    (b_emit),
        .q_class   (b_class),
        .q_seq_end (b_seq_end),
        .q_sum     (b_sum),
        .q_count   (b_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
